[hw/rtl/report_retry_protocol_top_assert.svh]
// Assertion macros shared by the report retry protocol checker.
`ifndef REPORT_RETRY_PROTOCOL_TOP_ASSERT_SVH
`define REPORT_RETRY_PROTOCOL_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rrp_pkg.sv]
// Types and constants of the report retry protocol controller.
package rrp_pkg;

  localparam logic [3:0] EV_TIMEOUT  = 4'd0;
  localparam logic [3:0] EV_CHECKSUM = 4'd1;
  localparam logic [3:0] EV_FRAME    = 4'd2;
  localparam logic [3:0] EV_UNKNOWN  = 4'd3;
  localparam logic [3:0] EV_AT_RESP  = 4'd4;
  localparam logic [3:0] EV_MODEM    = 4'd5;
  localparam logic [3:0] EV_NODE_ID  = 4'd6;
  localparam logic [3:0] EV_IO       = 4'd7;
  localparam logic [3:0] EV_TX_STAT  = 4'd8;
  localparam logic [3:0] EV_RX_PKT   = 4'd9;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_TIMEOUT  = 4'd1;
  localparam logic [3:0] ERR_CHECKSUM = 4'd2;
  localparam logic [3:0] ERR_FRAME    = 4'd3;
  localparam logic [3:0] ERR_UNKNOWN  = 4'd4;
  localparam logic [3:0] ERR_MODEM    = 4'd5;
  localparam logic [3:0] ERR_NODE     = 4'd6;
  localparam logic [3:0] ERR_IO       = 4'd7;
  localparam logic [3:0] ERR_COMMAND  = 4'd8;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ASSOC   = 3'd1;
  localparam logic [2:0] ACT_BATTERY = 3'd2;
  localparam logic [2:0] ACT_REPORT  = 3'd3;
  localparam logic [2:0] ACT_ACK     = 3'd4;
  localparam logic [2:0] ACT_ABANDON = 3'd5;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;

  localparam logic REG_ASSOC_LIMIT = 1'b0;
  localparam logic REG_SEND_LIMIT  = 1'b1;

  localparam logic [5:0]  ASSOC_LIMIT_RST = 6'd40;
  localparam logic [3:0]  SEND_LIMIT_RST  = 4'd3;
  localparam logic [6:0]  RETRY_MAX       = 7'd127;
  localparam logic [10:0] WAIT_ASSOC      = 11'd300;
  localparam logic [10:0] WAIT_BATTERY    = 11'd200;
  localparam logic [10:0] WAIT_REPORT     = 11'd2000;

  typedef struct packed {
    logic        mode;
    logic [3:0]  event_kind;
    logic [7:0]  at_status;
    logic [7:0]  at_cmd_first;
    logic [7:0]  at_cmd_second;
    logic [7:0]  at_data_first;
    logic        adc_present;
    logic [9:0]  adc_value;
    logic [7:0]  delivery_status;
    logic [7:0]  rx_first_char;
    logic [31:0] count_snapshot;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  report_letter;
    logic [31:0] report_word;
    logic [7:0]  report_checksum;
    logic [10:0] wait_ms;
    logic        battery_enable;
    logic        cycle_done;
    logic [31:0] count_consumed;
  } out_t;

endpackage

[hw/rtl/rrp_in_if.sv]
// Input channel of the report retry protocol controller.
interface rrp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  event_kind;
  logic [7:0]  at_status;
  logic [7:0]  at_cmd_first;
  logic [7:0]  at_cmd_second;
  logic [7:0]  at_data_first;
  logic        adc_present;
  logic [9:0]  adc_value;
  logic [7:0]  delivery_status;
  logic [7:0]  rx_first_char;
  logic [31:0] count_snapshot;

  modport source (
    output valid, mode, event_kind, at_status, at_cmd_first, at_cmd_second,
           at_data_first, adc_present, adc_value, delivery_status, rx_first_char,
           count_snapshot,
    input  ready
  );
  modport sink (
    input  valid, mode, event_kind, at_status, at_cmd_first, at_cmd_second,
           at_data_first, adc_present, adc_value, delivery_status, rx_first_char,
           count_snapshot,
    output ready
  );
endinterface

[hw/rtl/rrp_out_if.sv]
// Result channel of the report retry protocol controller.
interface rrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  report_letter;
  logic [31:0] report_word;
  logic [7:0]  report_checksum;
  logic [10:0] wait_ms;
  logic        battery_enable;
  logic        cycle_done;
  logic [31:0] count_consumed;

  modport source (
    output valid, action, report_letter, report_word, report_checksum, wait_ms,
           battery_enable, cycle_done, count_consumed,
    input  ready
  );
  modport sink (
    input  valid, action, report_letter, report_word, report_checksum, wait_ms,
           battery_enable, cycle_done, count_consumed,
    output ready
  );
endinterface

[hw/rtl/report_retry_protocol_top.sv]
// Top level of the report retry protocol controller.
// Each input beat is captured in an input register and processed from there when the result
// register is free or being emptied; the result is then held in a result register. One beat
// is taken every cycle while the result channel does not stall. The state update, the report
// word add and its byte checksum form the single combinational path between the registers.
// A start beat opens a report cycle, event beats drive the association, battery and report
// stages, and every accepted beat yields exactly one result beat.
module report_retry_protocol_top
  import rrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  rrp_in_if.sink     in_i,
  rrp_out_if.source  out_o
);

  typedef enum logic [1:0] {
    ST_ASSOC = 2'd0,
    ST_BATT  = 2'd1,
    ST_XMIT  = 2'd2
  } stage_e;

  logic        in_vld_q;
  in_t         in_q;
  logic        out_vld_q;
  out_t        out_q, out_d;
  logic        proc;

  logic [5:0]  assoc_lim_q;
  logic [3:0]  send_lim_q;
  stage_e      stage_q, stage_d;
  logic [6:0]  retry_q, retry_d;
  logic        retry_en_q, retry_en_d;
  logic        assoc_q, assoc_d;
  logic        batt_ok_q, batt_ok_d;
  logic        ack_q, ack_d;
  logic        nak_q, nak_d;
  logic [7:0]  dlv_q, dlv_d;
  logic [3:0]  err_q, err_d;
  logic [9:0]  volt_q, volt_d;
  logic [31:0] held_q, held_d;
  logic        active_q, active_d;
  logic        bat_sw_q, bat_sw_d;
  logic [10:0] wait_q, wait_d;

  assign proc       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || proc;

  always_comb begin
    logic        run;
    logic        done;
    logic [2:0]  act;
    logic [6:0]  param;
    logic [7:0]  letter;
    logic [31:0] word;
    logic [7:0]  sum8;

    stage_d    = stage_q;
    retry_d    = retry_q;
    retry_en_d = retry_en_q;
    assoc_d    = assoc_q;
    batt_ok_d  = batt_ok_q;
    ack_d      = ack_q;
    nak_d      = nak_q;
    dlv_d      = dlv_q;
    err_d      = err_q;
    volt_d     = volt_q;
    held_d     = held_q;
    active_d   = active_q;
    bat_sw_d   = bat_sw_q;
    wait_d     = wait_q;
    out_d      = '0;
    run        = 1'b0;
    done       = 1'b0;
    act        = ACT_NONE;
    param      = '0;
    letter     = CH_C;
    word       = '0;
    sum8       = '0;

    if (proc) begin
      if (!in_q.mode) begin
        stage_d    = ST_ASSOC;
        retry_d    = '0;
        retry_en_d = 1'b1;
        assoc_d    = 1'b0;
        batt_ok_d  = 1'b0;
        ack_d      = 1'b0;
        nak_d      = 1'b0;
        dlv_d      = '0;
        err_d      = ERR_UNKNOWN;
        volt_d     = '0;
        wait_d     = '0;
        held_d     = in_q.count_snapshot;
        active_d   = 1'b1;
        run        = 1'b1;
      end else if (active_q) begin
        run   = 1'b1;
        err_d = ERR_NONE;
        case (in_q.event_kind)
          EV_TIMEOUT:  err_d = ERR_TIMEOUT;
          EV_CHECKSUM: err_d = ERR_CHECKSUM;
          EV_FRAME:    err_d = ERR_FRAME;
          EV_UNKNOWN:  err_d = ERR_UNKNOWN;
          EV_AT_RESP: begin
            if (in_q.at_status != 8'd0) begin
              err_d = ERR_FRAME;
            end else begin
              if (in_q.at_cmd_first == CH_A && in_q.at_cmd_second == CH_I) begin
                if (stage_q != ST_ASSOC) retry_en_d = 1'b0;
                assoc_d = (in_q.at_data_first == 8'd0);
              end
              if (in_q.at_cmd_first == CH_I && in_q.at_cmd_second == CH_S) begin
                if (stage_q != ST_BATT) retry_en_d = 1'b0;
                batt_ok_d = 1'b1;
                if (in_q.adc_present) volt_d = in_q.adc_value;
              end
            end
          end
          EV_MODEM: begin
            err_d      = ERR_MODEM;
            retry_en_d = 1'b0;
          end
          EV_NODE_ID: begin
            err_d      = ERR_NODE;
            retry_en_d = 1'b0;
          end
          EV_IO: begin
            err_d      = ERR_IO;
            retry_en_d = 1'b0;
          end
          EV_TX_STAT: begin
            dlv_d      = in_q.delivery_status;
            retry_en_d = 1'b0;
          end
          EV_RX_PKT: begin
            if (stage_q == ST_XMIT) begin
              if (in_q.rx_first_char == CH_N) nak_d = 1'b1;
              else if (in_q.rx_first_char == CH_A) ack_d = 1'b1;
              else err_d = ERR_COMMAND;
            end else begin
              retry_en_d = 1'b0;
            end
            if (in_q.rx_first_char == CH_D) begin
              err_d      = ERR_NONE;
              retry_en_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    if (run) begin
      if (stage_d == ST_ASSOC) begin
        if (assoc_d || retry_d > {1'b0, assoc_lim_q}) begin
          retry_d = '0;
          stage_d = ST_BATT;
        end else begin
          wait_d = WAIT_ASSOC;
          if (retry_en_d) begin
            act = ACT_ASSOC;
            if (retry_d < RETRY_MAX) retry_d = retry_d + 7'd1;
          end
        end
        retry_en_d = 1'b1;
      end
      if (stage_d == ST_BATT) begin
        if (batt_ok_d || retry_d > {3'b0, send_lim_q}) begin
          bat_sw_d = 1'b0;
          retry_d  = '0;
          err_d    = ERR_NONE;
          nak_d    = 1'b0;
          ack_d    = 1'b0;
          stage_d  = ST_XMIT;
        end else begin
          wait_d = WAIT_BATTERY;
          if (retry_en_d) begin
            bat_sw_d = 1'b1;
            act      = ACT_BATTERY;
            if (retry_d < RETRY_MAX) retry_d = retry_d + 7'd1;
          end
        end
        retry_en_d = 1'b1;
      end
      if (stage_d == ST_XMIT) begin
        if (ack_d) begin
          act                  = ACT_ACK;
          out_d.count_consumed = held_d;
          retry_d              = '0;
          done                 = 1'b1;
        end else if (retry_d > {3'b0, send_lim_q}) begin
          act     = ACT_ABANDON;
          retry_d = '0;
          done    = 1'b1;
        end else begin
          wait_d = WAIT_REPORT;
          if (retry_en_d) begin
            param = retry_d;
            if (err_d == ERR_TIMEOUT) begin
              letter = CH_T;
            end else if (err_d != ERR_NONE) begin
              param  = {3'b0, err_d};
              letter = CH_E;
            end
            if (nak_d) letter = CH_N;
            if (dlv_d != 8'd0) begin
              param  = 7'd1;
              letter = CH_S;
            end
            word = held_d + {6'd0, volt_d, 16'd0} + {param[5:0], 26'd0};
            sum8 = word[7:0] + word[15:8] + word[23:16] + word[31:24];
            out_d.report_letter   = letter;
            out_d.report_word     = word;
            out_d.report_checksum = 8'd0 - sum8;
            act = ACT_REPORT;
            if (retry_d < RETRY_MAX) retry_d = retry_d + 7'd1;
          end
          retry_en_d = 1'b1;
          nak_d      = 1'b0;
        end
      end
      out_d.action     = act;
      out_d.wait_ms    = done ? 11'd0 : wait_d;
      out_d.cycle_done = done;
      if (done) active_d = 1'b0;
    end
    out_d.battery_enable = bat_sw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
      assoc_lim_q <= ASSOC_LIMIT_RST;
      send_lim_q  <= SEND_LIMIT_RST;
      stage_q     <= ST_ASSOC;
      retry_q     <= '0;
      retry_en_q  <= 1'b1;
      assoc_q     <= 1'b0;
      batt_ok_q   <= 1'b0;
      ack_q       <= 1'b0;
      nak_q       <= 1'b0;
      dlv_q       <= '0;
      err_q       <= ERR_UNKNOWN;
      volt_q      <= '0;
      held_q      <= '0;
      active_q    <= 1'b0;
      bat_sw_q    <= 1'b0;
      wait_q      <= '0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (proc) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
      if (proc) out_q <= out_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ASSOC_LIMIT: assoc_lim_q <= cfg_data_i;
          REG_SEND_LIMIT:  send_lim_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      stage_q    <= stage_d;
      retry_q    <= retry_d;
      retry_en_q <= retry_en_d;
      assoc_q    <= assoc_d;
      batt_ok_q  <= batt_ok_d;
      ack_q      <= ack_d;
      nak_q      <= nak_d;
      dlv_q      <= dlv_d;
      err_q      <= err_d;
      volt_q     <= volt_d;
      held_q     <= held_d;
      active_q   <= active_d;
      bat_sw_q   <= bat_sw_d;
      wait_q     <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.mode            <= in_i.mode;
      in_q.event_kind      <= in_i.event_kind;
      in_q.at_status       <= in_i.at_status;
      in_q.at_cmd_first    <= in_i.at_cmd_first;
      in_q.at_cmd_second   <= in_i.at_cmd_second;
      in_q.at_data_first   <= in_i.at_data_first;
      in_q.adc_present     <= in_i.adc_present;
      in_q.adc_value       <= in_i.adc_value;
      in_q.delivery_status <= in_i.delivery_status;
      in_q.rx_first_char   <= in_i.rx_first_char;
      in_q.count_snapshot  <= in_i.count_snapshot;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.action          = out_q.action;
  assign out_o.report_letter   = out_q.report_letter;
  assign out_o.report_word     = out_q.report_word;
  assign out_o.report_checksum = out_q.report_checksum;
  assign out_o.wait_ms         = out_q.wait_ms;
  assign out_o.battery_enable  = out_q.battery_enable;
  assign out_o.cycle_done      = out_q.cycle_done;
  assign out_o.count_consumed  = out_q.count_consumed;

endmodule

[hw/rtl/rrp_checker.sv]
// Port-level checker of the report retry protocol controller and its bind.
`include "report_retry_protocol_top_assert.svh"

module rrp_checker
  import rrp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  action_i,
  input logic [7:0]  report_letter_i,
  input logic [31:0] report_word_i,
  input logic [7:0]  report_checksum_i,
  input logic [10:0] wait_ms_i,
  input logic        cycle_done_i,
  input logic [31:0] count_consumed_i
);

  `RRP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(action_i) && $stable(report_word_i), "Stalled result beat changed.")
  `RRP_ASSERT_NOW(a_done_end, out_valid_i && cycle_done_i, wait_ms_i == 11'd0 && (action_i == ACT_ACK || action_i == ACT_ABANDON), "Finished cycle without ack or abandon.")
  `RRP_ASSERT_NOW(a_consume_ack, out_valid_i && count_consumed_i != 32'd0, action_i == ACT_ACK && cycle_done_i, "Count released without ack.")
  `RRP_ASSERT_NOW(a_report_sum, out_valid_i && action_i == ACT_REPORT, 8'(report_checksum_i + report_word_i[7:0] + report_word_i[15:8] + report_word_i[23:16] + report_word_i[31:24]) == 8'd0 && report_letter_i != 8'd0, "Report checksum mismatch.")

endmodule

bind report_retry_protocol_top rrp_checker u_rrp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .action_i          (out_o.action),
  .report_letter_i   (out_o.report_letter),
  .report_word_i     (out_o.report_word),
  .report_checksum_i (out_o.report_checksum),
  .wait_ms_i         (out_o.wait_ms),
  .cycle_done_i      (out_o.cycle_done),
  .count_consumed_i  (out_o.count_consumed)
);

[verif/tb_report_retry_protocol_top.sv]
// Self-checking testbench of the report retry protocol controller with its own predictor.
module tb_report_retry_protocol_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  localparam logic [1:0] STG_ASSOC   = 2'd0;
  localparam logic [1:0] STG_BATTERY = 2'd1;
  localparam logic [1:0] STG_REPORT  = 2'd2;
  localparam logic       MODE_START  = 1'b0;
  localparam logic       MODE_EVENT  = 1'b1;
  localparam int         LIMIT_CYCLES = 300000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [5:0] cfg_data;

  rrp_in_if  in_if ();
  rrp_out_if out_if ();

  report_retry_protocol_top u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Predicted controller state.
  logic [5:0]  lim_assoc;
  logic [3:0]  lim_send;
  logic [1:0]  cur_stage;
  logic [6:0]  tries;
  logic        retry_armed;
  logic        assoc_seen;
  logic        batt_answered;
  logic        ack_seen;
  logic        nak_seen;
  logic [7:0]  deliv_code;
  logic [3:0]  err_code;
  logic [9:0]  batt_level;
  logic [31:0] held_count;
  logic        cycle_open;
  logic        batt_switch;
  logic [10:0] wait_hold;

  out_t awaited_results[$];
  int   fail_count;
  int   burst_left;
  int   live_beats;

  function automatic void clear_cycle();
    cur_stage     = STG_ASSOC;
    tries         = '0;
    retry_armed   = 1'b1;
    assoc_seen    = 1'b0;
    batt_answered = 1'b0;
    ack_seen      = 1'b0;
    nak_seen      = 1'b0;
    deliv_code    = '0;
    err_code      = ERR_UNKNOWN;
    batt_level    = '0;
    wait_hold     = '0;
  endfunction

  function automatic void bump_tries();
    if (tries < RETRY_MAX) tries = tries + 7'd1;
  endfunction

  function automatic out_t protocol_step(in_t it);
    out_t        res;
    logic        done;
    logic [6:0]  param;
    logic [7:0]  letter;
    logic [31:0] word;
    logic [7:0]  bsum;
    res  = '0;
    done = 1'b0;
    if (it.mode == MODE_START) begin
      clear_cycle();
      held_count = it.count_snapshot;
      cycle_open = 1'b1;
    end else if (cycle_open) begin
      err_code = ERR_NONE;
      case (it.event_kind)
        EV_TIMEOUT:  err_code = ERR_TIMEOUT;
        EV_CHECKSUM: err_code = ERR_CHECKSUM;
        EV_FRAME:    err_code = ERR_FRAME;
        EV_UNKNOWN:  err_code = ERR_UNKNOWN;
        EV_AT_RESP: begin
          if (it.at_status != 8'd0) begin
            err_code = ERR_FRAME;
          end else begin
            if (it.at_cmd_first == CH_A && it.at_cmd_second == CH_I) begin
              if (cur_stage != STG_ASSOC) retry_armed = 1'b0;
              assoc_seen = (it.at_data_first == 8'd0);
            end
            if (it.at_cmd_first == CH_I && it.at_cmd_second == CH_S) begin
              if (cur_stage != STG_BATTERY) retry_armed = 1'b0;
              batt_answered = 1'b1;
              if (it.adc_present) batt_level = it.adc_value;
            end
          end
        end
        EV_MODEM: begin
          err_code    = ERR_MODEM;
          retry_armed = 1'b0;
        end
        EV_NODE_ID: begin
          err_code    = ERR_NODE;
          retry_armed = 1'b0;
        end
        EV_IO: begin
          err_code    = ERR_IO;
          retry_armed = 1'b0;
        end
        EV_TX_STAT: begin
          deliv_code  = it.delivery_status;
          retry_armed = 1'b0;
        end
        EV_RX_PKT: begin
          if (cur_stage == STG_REPORT) begin
            if (it.rx_first_char == CH_N) nak_seen = 1'b1;
            else if (it.rx_first_char == CH_A) ack_seen = 1'b1;
            else err_code = ERR_COMMAND;
          end else begin
            retry_armed = 1'b0;
          end
          if (it.rx_first_char == CH_D) begin
            err_code    = ERR_NONE;
            retry_armed = 1'b0;
          end
        end
        default: ;
      endcase
    end else begin
      res.battery_enable = batt_switch;
      return res;
    end

    if (cur_stage == STG_ASSOC) begin
      if (assoc_seen || tries > {1'b0, lim_assoc}) begin
        tries     = '0;
        cur_stage = STG_BATTERY;
      end else begin
        wait_hold = WAIT_ASSOC;
        if (retry_armed) begin
          res.action = ACT_ASSOC;
          bump_tries();
        end
      end
      retry_armed = 1'b1;
    end
    if (cur_stage == STG_BATTERY) begin
      if (batt_answered || tries > {3'b0, lim_send}) begin
        batt_switch = 1'b0;
        tries       = '0;
        err_code    = ERR_NONE;
        nak_seen    = 1'b0;
        ack_seen    = 1'b0;
        cur_stage   = STG_REPORT;
      end else begin
        wait_hold = WAIT_BATTERY;
        if (retry_armed) begin
          batt_switch = 1'b1;
          res.action  = ACT_BATTERY;
          bump_tries();
        end
      end
      retry_armed = 1'b1;
    end
    if (cur_stage == STG_REPORT) begin
      if (ack_seen) begin
        res.action         = ACT_ACK;
        res.count_consumed = held_count;
        tries              = '0;
        done               = 1'b1;
      end else if (tries > {3'b0, lim_send}) begin
        res.action = ACT_ABANDON;
        tries      = '0;
        done       = 1'b1;
      end else begin
        wait_hold = WAIT_REPORT;
        if (retry_armed) begin
          param  = tries;
          letter = CH_C;
          if (err_code == ERR_TIMEOUT) begin
            letter = CH_T;
          end else if (err_code != ERR_NONE) begin
            param  = {3'b0, err_code};
            letter = CH_E;
          end
          if (nak_seen) letter = CH_N;
          if (deliv_code != 8'd0) begin
            param  = 7'd1;
            letter = CH_S;
          end
          word = held_count + {6'd0, batt_level, 16'd0} + {param[5:0], 26'd0};
          bsum = word[7:0] + word[15:8] + word[23:16] + word[31:24];
          res.report_letter   = letter;
          res.report_word     = word;
          res.report_checksum = 8'd0 - bsum;
          res.action          = ACT_REPORT;
          bump_tries();
        end
        retry_armed = 1'b1;
        nak_seen    = 1'b0;
      end
    end

    res.wait_ms        = done ? 11'd0 : wait_hold;
    res.battery_enable = batt_switch;
    res.cycle_done     = done;
    if (done) cycle_open = 1'b0;
    return res;
  endfunction

  function automatic in_t noise_event();
    in_t it;
    it.mode            = MODE_EVENT;
    it.event_kind      = 4'($urandom);
    it.at_status       = 8'($urandom);
    it.at_cmd_first    = 8'($urandom);
    it.at_cmd_second   = 8'($urandom);
    it.at_data_first   = 8'($urandom);
    it.adc_present     = 1'($urandom);
    it.adc_value       = 10'($urandom);
    it.delivery_status = 8'($urandom);
    it.rx_first_char   = 8'($urandom);
    it.count_snapshot  = $urandom;
    return it;
  endfunction

  function automatic in_t make_event(logic [3:0] kind);
    in_t it;
    it            = noise_event();
    it.event_kind = kind;
    return it;
  endfunction

  function automatic in_t start_beat(logic [31:0] cnt);
    in_t it;
    it                = noise_event();
    it.mode           = MODE_START;
    it.count_snapshot = cnt;
    return it;
  endfunction

  function automatic in_t at_reply(logic [7:0] c1, logic [7:0] c2, logic [7:0] data);
    in_t it;
    it               = make_event(EV_AT_RESP);
    it.at_status     = 8'd0;
    it.at_cmd_first  = c1;
    it.at_cmd_second = c2;
    it.at_data_first = data;
    return it;
  endfunction

  function automatic in_t rx_frame(logic [7:0] ch);
    in_t it;
    it               = make_event(EV_RX_PKT);
    it.rx_first_char = ch;
    return it;
  endfunction

  task automatic send_beat(input in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= item.mode;
    in_if.event_kind      <= item.event_kind;
    in_if.at_status       <= item.at_status;
    in_if.at_cmd_first    <= item.at_cmd_first;
    in_if.at_cmd_second   <= item.at_cmd_second;
    in_if.at_data_first   <= item.at_data_first;
    in_if.adc_present     <= item.adc_present;
    in_if.adc_value       <= item.adc_value;
    in_if.delivery_status <= item.delivery_status;
    in_if.rx_first_char   <= item.rx_first_char;
    in_if.count_snapshot  <= item.count_snapshot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (item.mode == MODE_START || cycle_open) live_beats++;
    awaited_results.push_back(protocol_step(item));
    burst_left--;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [5:0] assoc_lim, input logic [3:0] send_lim);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ASSOC_LIMIT;
    cfg_data <= assoc_lim;
    @(posedge clk);
    cfg_idx  <= REG_SEND_LIMIT;
    cfg_data <= {2'b00, send_lim};
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_assoc = assoc_lim;
    lim_send  = send_lim;
  endtask

  function automatic in_t pick_event(int luck);
    in_t it;
    int  r;
    it = noise_event();
    r  = $urandom_range(0, 99);
    if (r < 6) return it;
    if (r < 8) return rx_frame(CH_D);
    if (r < 9) begin
      it.mode = MODE_START;
      return it;
    end
    if (r < 11) begin
      it            = at_reply(CH_A, CH_I, 8'd0);
      it.at_status  = 8'($urandom_range(1, 255));
      return it;
    end
    r = $urandom_range(0, 99);
    case (cur_stage)
      STG_ASSOC: begin
        if (r < luck) it = at_reply(CH_A, CH_I, 8'd0);
        else if (r < luck + 20) it = at_reply(CH_A, CH_I, 8'($urandom_range(1, 255)));
        else it = make_event(EV_TIMEOUT);
      end
      STG_BATTERY: begin
        if (r < luck) it = at_reply(CH_I, CH_S, 8'($urandom));
        else if (r < luck + 10) it = at_reply(CH_A, CH_I, 8'($urandom));
        else it = make_event(EV_TIMEOUT);
      end
      default: begin
        if (r < luck) begin
          it = rx_frame(CH_A);
        end else if (r < luck + 10) begin
          it = rx_frame(CH_N);
        end else if (r < luck + 20) begin
          it = make_event(EV_TX_STAT);
          if ($urandom_range(0, 1) == 0) it.delivery_status = 8'd0;
        end else if (r < luck + 30) begin
          it = rx_frame(8'($urandom));
        end else if (r < luck + 40) begin
          case ($urandom_range(0, 5))
            0: it = make_event(EV_CHECKSUM);
            1: it = make_event(EV_FRAME);
            2: it = make_event(EV_UNKNOWN);
            3: it = make_event(EV_MODEM);
            4: it = make_event(EV_NODE_ID);
            default: it = make_event(EV_IO);
          endcase
        end else begin
          it = make_event(EV_TIMEOUT);
        end
      end
    endcase
    return it;
  endfunction

  task automatic run_report_cycle();
    int          steps;
    int          luck;
    logic [31:0] cnt;
    case ($urandom_range(0, 2))
      0: luck = 3;
      1: luck = 25;
      default: luck = 50;
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 32'hFFFF_FFFF;
      1: cnt = 32'd0;
      default: cnt = $urandom;
    endcase
    send_beat(start_beat(cnt));
    steps = 0;
    while (cycle_open && steps < 200) begin
      send_beat(pick_event(luck));
      steps++;
    end
  endtask

  task automatic test_idle_events();
    in_t it;
    send_beat(make_event(EV_TIMEOUT));
    it            = noise_event();
    it.event_kind = 4'hF;
    send_beat(it);
    send_beat(rx_frame(CH_A));
  endtask

  task automatic test_full_cycle();
    in_t it;
    load_limits(6'd63, 4'd15);
    send_beat(start_beat(32'hFFFF_FFFF));
    send_beat(at_reply(CH_A, CH_I, 8'd7));
    it           = at_reply(CH_A, CH_I, 8'd0);
    it.at_status = 8'hFF;
    send_beat(it);
    send_beat(at_reply(CH_A, CH_I, 8'd0));
    send_beat(make_event(EV_TIMEOUT));
    it             = at_reply(CH_I, CH_S, 8'd0);
    it.adc_present = 1'b1;
    it.adc_value   = 10'h3FF;
    send_beat(it);
    send_beat(make_event(EV_TIMEOUT));
    send_beat(make_event(EV_CHECKSUM));
    send_beat(make_event(EV_MODEM));
    send_beat(rx_frame(CH_N));
    send_beat(rx_frame(CH_D));
    it                 = make_event(EV_TX_STAT);
    it.delivery_status = 8'h80;
    send_beat(it);
    send_beat(make_event(EV_TIMEOUT));
    send_beat(rx_frame(CH_A));
  endtask

  task automatic test_abandon();
    in_t it;
    load_limits(6'd0, 4'd1);
    send_beat(start_beat(32'd0));
    it             = at_reply(CH_I, CH_S, 8'd0);
    it.adc_present = 1'b0;
    send_beat(it);
    send_beat(make_event(EV_FRAME));
    send_beat(rx_frame(CH_T));
    it            = noise_event();
    it.event_kind = 4'd10;
    send_beat(it);
    send_beat(start_beat(32'h1234_5678));
    send_beat(start_beat(32'h0000_FFFF));
    send_beat(rx_frame(CH_A));
    send_beat(make_event(EV_NODE_ID));
    send_beat(make_event(EV_IO));
    send_beat(make_event(EV_UNKNOWN));
    send_beat(make_event(EV_TIMEOUT));
  endtask

  task automatic test_random_cycles();
    logic [5:0] a_lim;
    logic [3:0] s_lim;
    int         goal;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin a_lim = 6'd0;  s_lim = 4'd0;  end
        1: begin a_lim = 6'd63; s_lim = 4'd15; end
        2: begin a_lim = ASSOC_LIMIT_RST; s_lim = SEND_LIMIT_RST; end
        default: begin a_lim = 6'($urandom); s_lim = 4'($urandom); end
      endcase
      load_limits(a_lim, s_lim);
      goal = live_beats + 142;
      while (live_beats < goal) begin
        run_report_cycle();
        if ($urandom_range(0, 3) == 0) send_beat(noise_event());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int   idle_left;
    int   style;
    int   tick;
    out_t got;
    out_t exp;
    out_if.ready <= 1'b0;
    idle_left = 0;
    style     = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got.action          = out_if.action;
        got.report_letter   = out_if.report_letter;
        got.report_word     = out_if.report_word;
        got.report_checksum = out_if.report_checksum;
        got.wait_ms         = out_if.wait_ms;
        got.battery_enable  = out_if.battery_enable;
        got.cycle_done      = out_if.cycle_done;
        got.count_consumed  = out_if.count_consumed;
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat, action %0d", got.action);
          fail_count++;
        end else begin
          exp = awaited_results.pop_front();
          if (got.action !== exp.action || got.report_letter !== exp.report_letter ||
              got.report_word !== exp.report_word ||
              got.report_checksum !== exp.report_checksum || got.wait_ms !== exp.wait_ms ||
              got.battery_enable !== exp.battery_enable ||
              got.cycle_done !== exp.cycle_done ||
              got.count_consumed !== exp.count_consumed) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: action %0d/%0d letter %h/%h word %h/%h sum %h/%h",
                       $realtime, exp.action, got.action, exp.report_letter,
                       got.report_letter, exp.report_word, got.report_word,
                       exp.report_checksum, got.report_checksum);
              $display("  wait %0d/%0d battery %b/%b done %b/%b consumed %h/%h",
                       exp.wait_ms, got.wait_ms, exp.battery_enable, got.battery_enable,
                       exp.cycle_done, got.cycle_done, exp.count_consumed,
                       got.count_consumed);
            end
            fail_count++;
          end
        end
      end
      if (idle_left == 0) begin
        style     = $urandom_range(0, 3);
        idle_left = $urandom_range(16, 96);
      end else begin
        idle_left--;
      end
      case (style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (tick % 5 == 0);
      endcase
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[report_retry_protocol_top] ERROR");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= REG_ASSOC_LIMIT;
    cfg_data    <= '0;
    in_if.valid <= 1'b0;
    in_if.mode  <= MODE_EVENT;
    in_if.event_kind      <= '0;
    in_if.at_status       <= '0;
    in_if.at_cmd_first    <= '0;
    in_if.at_cmd_second   <= '0;
    in_if.at_data_first   <= '0;
    in_if.adc_present     <= 1'b0;
    in_if.adc_value       <= '0;
    in_if.delivery_status <= '0;
    in_if.rx_first_char   <= '0;
    in_if.count_snapshot  <= '0;
    lim_assoc   = ASSOC_LIMIT_RST;
    lim_send    = SEND_LIMIT_RST;
    clear_cycle();
    held_count  = '0;
    cycle_open  = 1'b0;
    batt_switch = 1'b0;
    fail_count  = 0;
    burst_left  = 0;
    live_beats  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_events();
    test_full_cycle();
    test_abandon();
    test_random_cycles();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[report_retry_protocol_top] OK");
    end else begin
      $display("[report_retry_protocol_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_in_if.sv
hw/rtl/rrp_out_if.sv
hw/rtl/report_retry_protocol_top.sv
hw/rtl/rrp_checker.sv
verif/tb_report_retry_protocol_top.sv
